// ===== rtl/ngba_pkg.sv =====
// ----------------------------------------------------------------------------
// ngba_pkg
// Shared types and constants of the nearest-group bitmap allocator.
// ----------------------------------------------------------------------------
package ngba_pkg;

    // Field widths fixed by the item format
    localparam int GROUP_W    = 4;
    localparam int WIDX_W     = 8;
    localparam int WORD_W     = 32;
    localparam int GC_W       = 5;
    localparam int PER_W      = 14;
    localparam int ID_W       = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int IN_USER_W  = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_USER_W = 1;
    localparam int OUT_DATA_W = 32;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Bitmap kinds
    localparam logic KIND_BLOCK = 1'b0;
    localparam logic KIND_INODE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

    // Register reset values
    localparam logic [GC_W-1:0]  GROUP_COUNT_RST = 5'd16;
    localparam logic [PER_W-1:0] PER_GROUP_RST   = 14'd8192;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic load_write;
        logic alloc_init;
        logic start_scan;
        logic scan_en;
        logic step_cand;
        logic set_bit;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic cand_valid;
        logic exhausted;
        logic scan_hit;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/ngba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ngba_ctrl
// Sequencer of the allocator: clearing pass, load, outward group search.
// ----------------------------------------------------------------------------
module ngba_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_cmd,
    output logic                 s_tready,
    input  ngba_pkg::dp_status_t status,
    output ngba_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_INIT,
        S_CAND,
        S_SCAN,
        S_SETBIT,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (s_cmd == ngba_pkg::CMD_ALLOC) ? S_INIT : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_write = 1'b1;
                state_next     = S_RESULT;
            end
            S_INIT:
            begin
                cmd.alloc_init = 1'b1;
                state_next     = S_CAND;
            end
            S_CAND:
            begin
                if (status.exhausted)
                begin
                    state_next = S_RESULT;
                end
                else if (status.cand_valid)
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cmd.step_cand = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_hit)
                begin
                    state_next = S_SETBIT;
                end
                else if (status.scan_done)
                begin
                    cmd.step_cand = 1'b1;
                    state_next    = S_CAND;
                end
            end
            S_SETBIT:
            begin
                cmd.set_bit = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ngba_datapath.sv =====
// ----------------------------------------------------------------------------
// ngba_datapath
// Bitmap memories, config registers, group/word counters, bit finder and
// result register of the allocator.
// ----------------------------------------------------------------------------
module ngba_datapath
#(
    parameter int MAX_GROUPS      = 16,
    parameter int WORDS_PER_GROUP = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ngba_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ngba_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [ngba_pkg::IN_USER_W-1:0]      s_tuser,
    input  logic [ngba_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ngba_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic [ngba_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  ngba_pkg::dp_cmd_t                   cmd,
    output ngba_pkg::dp_status_t                status
);

    localparam int DEPTH = MAX_GROUPS * WORDS_PER_GROUP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GIW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int WIW   = (WORDS_PER_GROUP > 1) ? $clog2(WORDS_PER_GROUP) : 1;
    localparam int WCW   = $clog2(WORDS_PER_GROUP + 1);
    localparam int DW    = $clog2(MAX_GROUPS + 16) + 1;
    localparam int CAP   = WORDS_PER_GROUP * 32;
    localparam int PW    = ngba_pkg::PER_W;
    localparam int PRW   = GIW + PW;
    localparam int WW    = ngba_pkg::WORD_W;

    // Config registers
    logic [ngba_pkg::GC_W-1:0] group_count_reg;
    logic [PW-1:0]             inodes_reg;
    logic [PW-1:0]             blocks_reg;

    // Captured item
    logic                             cmd_reg;
    logic                             kind_reg;
    logic [ngba_pkg::GROUP_W-1:0]     home_reg;
    logic [ngba_pkg::WIDX_W-1:0]      widx_reg;
    logic [WW-1:0]                    data_reg;

    // Search and scan state
    logic [AW-1:0]   clear_addr_reg;
    logic [DW-1:0]   d_reg;
    logic            side_reg;
    logic [WCW-1:0]  wcnt_reg;
    logic            pend_reg;
    logic [WIW-1:0]  pend_word_reg;
    logic [AW-1:0]   pend_addr_reg;
    logic            hit_reg;
    logic [AW-1:0]   hit_addr_reg;
    logic [WW-1:0]   hit_word_reg;
    logic [PW-1:0]   hit_bit_reg;
    logic [GIW-1:0]  hit_group_reg;
    logic [PRW-1:0]  prod_reg;

    // Result register
    logic            m_valid_reg;
    logic            out_found_reg;
    logic [ngba_pkg::ID_W-1:0] out_id_reg;

    // Memories
    logic [WW-1:0] blk_mem [DEPTH];
    logic [WW-1:0] ino_mem [DEPTH];
    logic [WW-1:0] blk_rdata_reg;
    logic [WW-1:0] ino_rdata_reg;

    logic [DW-1:0]  gc_eff;
    logic [DW-1:0]  home_ext;
    logic [DW-1:0]  cand_lo;
    logic [DW-1:0]  cand_hi;
    logic [DW-1:0]  cand;
    logic [GIW-1:0] cand_g;
    logic [PW-1:0]  per;
    logic [PW-1:0]  limit;
    logic [WCW-1:0] nwords;
    logic [4:0]     tail;
    logic           issue_more;
    logic [AW-1:0]  scan_addr;
    logic [AW-1:0]  load_addr;
    logic           load_in_range;
    logic [WW-1:0]  rword;
    logic           last_word;
    logic [WW-1:0]  mask;
    logic [WW-1:0]  free_bits;
    logic [4:0]     hit_b;
    logic           scan_hit;
    logic           rd_en;
    logic           blk_we;
    logic           ino_we;
    logic [AW-1:0]  waddr;
    logic [WW-1:0]  wdata;
    logic [ngba_pkg::ID_W-1:0] alloc_id;

    // Effective group count and bits scanned per group
    always_comb
    begin
        gc_eff = (DW'(group_count_reg) < DW'(MAX_GROUPS)) ? DW'(group_count_reg)
                                                          : DW'(MAX_GROUPS);
        per    = (kind_reg == ngba_pkg::KIND_INODE) ? inodes_reg : blocks_reg;
        limit  = (32'(per) < CAP) ? per : PW'(CAP);
        nwords = WCW'((15'(limit) + 15'd31) >> 5);
        tail   = limit[4:0];
    end

    // Outward candidate: home - d, then home + d
    assign home_ext = DW'(home_reg);
    assign cand_lo  = home_ext - d_reg;
    assign cand_hi  = home_ext + d_reg;
    assign cand     = side_reg ? cand_hi : cand_lo;
    assign cand_g   = cand[GIW-1:0];

    assign status.cand_valid = side_reg ? ((d_reg != '0) && (cand_hi < gc_eff))
                                        : ((d_reg <= home_ext) && (cand_lo < gc_eff));
    assign status.exhausted  = (d_reg > home_ext) && (cand_hi >= gc_eff);

    assign issue_more = (wcnt_reg < nwords);
    assign scan_addr  = AW'(AW'(cand_g) * AW'(WORDS_PER_GROUP) + AW'(wcnt_reg[WIW-1:0]));
    assign load_addr  = AW'(AW'(home_reg) * AW'(WORDS_PER_GROUP) + AW'(widx_reg));
    assign load_in_range = (32'(home_reg) < MAX_GROUPS) && (32'(widx_reg) < WORDS_PER_GROUP);

    // Free-bit search in the word read last cycle
    assign rword     = (kind_reg == ngba_pkg::KIND_INODE) ? ino_rdata_reg : blk_rdata_reg;
    assign last_word = (WCW'(pend_word_reg) == nwords - WCW'(1));
    assign mask      = (last_word && (tail != 5'd0)) ? ((32'd1 << tail) - 32'd1) : '1;
    assign free_bits = ~rword & mask;

    always_comb
    begin
        hit_b = 5'd0;
        for (int i = WW - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                hit_b = 5'(i);
            end
        end
    end

    assign scan_hit         = pend_reg && (free_bits != '0);
    assign status.scan_hit  = scan_hit;
    assign status.scan_done = !pend_reg && !issue_more;
    assign rd_en            = cmd.scan_en && !scan_hit && issue_more;

    assign status.clear_last = (clear_addr_reg == AW'(DEPTH - 1));
    assign status.out_free   = !m_valid_reg || m_tready;

    // Write port select
    always_comb
    begin
        blk_we = 1'b0;
        ino_we = 1'b0;
        waddr  = clear_addr_reg;
        wdata  = '0;
        if (cmd.clear_step)
        begin
            blk_we = 1'b1;
            ino_we = 1'b1;
        end
        else if (cmd.load_write)
        begin
            waddr  = load_addr;
            wdata  = data_reg;
            blk_we = load_in_range && (kind_reg == ngba_pkg::KIND_BLOCK);
            ino_we = load_in_range && (kind_reg == ngba_pkg::KIND_INODE);
        end
        else if (cmd.set_bit)
        begin
            waddr  = hit_addr_reg;
            wdata  = hit_word_reg;
            blk_we = (kind_reg == ngba_pkg::KIND_BLOCK);
            ino_we = (kind_reg == ngba_pkg::KIND_INODE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            blk_rdata_reg <= blk_mem[scan_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ino_we)
        begin
            ino_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            ino_rdata_reg <= ino_mem[scan_addr];
        end
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= ngba_pkg::GROUP_COUNT_RST;
            inodes_reg      <= ngba_pkg::PER_GROUP_RST;
            blocks_reg      <= ngba_pkg::PER_GROUP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ngba_pkg::REG_GROUP_COUNT: group_count_reg <= cfg_data[ngba_pkg::GC_W-1:0];
                ngba_pkg::REG_INODE_COUNT: inodes_reg      <= cfg_data;
                ngba_pkg::REG_BLOCK_COUNT: blocks_reg      <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Control state of the search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            d_reg          <= '0;
            side_reg       <= 1'b0;
            wcnt_reg       <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
            if (cmd.accept)
            begin
                hit_reg <= 1'b0;
            end
            if (cmd.alloc_init)
            begin
                d_reg    <= '0;
                side_reg <= 1'b0;
            end
            else if (cmd.step_cand)
            begin
                if (side_reg)
                begin
                    d_reg    <= d_reg + DW'(1);
                    side_reg <= 1'b0;
                end
                else
                begin
                    side_reg <= 1'b1;
                end
            end
            if (cmd.start_scan)
            begin
                wcnt_reg <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan_en)
            begin
                if (scan_hit)
                begin
                    pend_reg <= 1'b0;
                    hit_reg  <= 1'b1;
                end
                else
                begin
                    pend_reg <= issue_more;
                    if (issue_more)
                    begin
                        wcnt_reg <= wcnt_reg + WCW'(1);
                    end
                end
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign alloc_id = ngba_pkg::ID_W'(prod_reg) + ngba_pkg::ID_W'(hit_bit_reg)
                    + ngba_pkg::ID_W'(kind_reg);

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg  <= s_tuser[0];
            kind_reg <= s_tuser[1];
            home_reg <= s_tdata[3:0];
            widx_reg <= s_tdata[11:4];
            data_reg <= s_tdata[43:12];
        end
        if (rd_en)
        begin
            pend_word_reg <= wcnt_reg[WIW-1:0];
            pend_addr_reg <= scan_addr;
        end
        if (cmd.scan_en && scan_hit)
        begin
            hit_addr_reg  <= pend_addr_reg;
            hit_word_reg  <= rword | (32'd1 << hit_b);
            hit_bit_reg   <= PW'({pend_word_reg, hit_b});
            hit_group_reg <= cand_g;
        end
        if (cmd.set_bit)
        begin
            prod_reg <= PRW'(hit_group_reg) * PRW'(per);
        end
        if (cmd.out_load)
        begin
            out_found_reg <= (cmd_reg == ngba_pkg::CMD_LOAD) ? load_in_range : hit_reg;
            out_id_reg    <= ((cmd_reg == ngba_pkg::CMD_ALLOC) && hit_reg) ? alloc_id : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_id_reg;

endmodule

// ===== rtl/nearest_group_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// nearest_group_bitmap_allocator
// Inode and data-block bitmap allocator with nearest-group search.
// ----------------------------------------------------------------------------
// Usage:
//   Input items on the s_ side: a load writes one 32-bit bitmap word of a
//   group; an allocate takes the lowest free bit of the home group, else of
//   home-1, home+1, home-2, ... among the groups in use, and marks it used.
//   Each item gives one result item on the m_ side: found flag in m_tuser,
//   inode id or block number in m_tdata.
//   Config (group count, inode and block counts per group) is written
//   through cfg_we/cfg_addr/cfg_data while the block is idle.
// Sequence (one item at a time):
//   load: accept, write of the bitmap word, result.
//   allocate: accept, init, then for each candidate group position a
//   check and, for each group in use that is scanned, a read of its
//   words up to the one with the free bit; one bitmap word is read per
//   cycle during a scan; a found bit is set before the result.
// Reset: both bitmaps are cleared one word a cycle, all MAX_GROUPS *
//   WORDS_PER_GROUP words (4096 by default); s_tready stays low meanwhile.
// Stall: a result waits in the output register; the next item is accepted,
//   and its result waits until the pending one is taken.
// ----------------------------------------------------------------------------
module nearest_group_bitmap_allocator
#(
    parameter int MAX_GROUPS      = 16,
    parameter int WORDS_PER_GROUP = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ngba_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ngba_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ngba_pkg::IN_USER_W-1:0]      s_tuser,   // cmd, kind
    input  logic [ngba_pkg::IN_DATA_W-1:0]      s_tdata,   // group, word_index, word_data, pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ngba_pkg::OUT_USER_W-1:0]     m_tuser,   // found
    output logic [ngba_pkg::OUT_DATA_W-1:0]     m_tdata    // object_id
);

    ngba_pkg::dp_cmd_t    cmd;
    ngba_pkg::dp_status_t status;

    ngba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ngba_datapath
    #(
        .MAX_GROUPS      (MAX_GROUPS),
        .WORDS_PER_GROUP (WORDS_PER_GROUP)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ===== test/ngba_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ngba_result_checker
// Watches the config port and both streams of the bitmap allocator, keeps
// its own copy of both bitmaps and the registers, predicts the found flag
// and object id of every accepted item and compares them in order.
// ----------------------------------------------------------------------------
module ngba_result_checker
#(
    parameter int MAX_GROUPS      = 16,
    parameter int WORDS_PER_GROUP = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ngba_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ngba_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ngba_pkg::IN_USER_W-1:0]      s_tuser,   // cmd, kind
    input  logic [ngba_pkg::IN_DATA_W-1:0]      s_tdata,   // group, word_index, word_data, pad
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ngba_pkg::OUT_USER_W-1:0]     m_tuser,   // found
    input  logic [ngba_pkg::OUT_DATA_W-1:0]     m_tdata,   // object_id
    output int                                  fail_count
);

    localparam int MAP_WORDS = MAX_GROUPS * WORDS_PER_GROUP;
    localparam int BIT_CAP   = WORDS_PER_GROUP * 32;

    typedef struct packed {
        logic                      found;
        logic [ngba_pkg::ID_W-1:0] object_id;
    } grant_t;

    logic [ngba_pkg::WORD_W-1:0] inode_bits [MAP_WORDS];
    logic [ngba_pkg::WORD_W-1:0] block_bits [MAP_WORDS];
    logic [ngba_pkg::GC_W-1:0]   cur_group_count;
    logic [ngba_pkg::PER_W-1:0]  cur_inodes;
    logic [ngba_pkg::PER_W-1:0]  cur_blocks;

    grant_t pending_grants[$];
    int     mismatch_count = 0;
    int     unanswered     = 0;

    assign fail_count = mismatch_count + unanswered;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Lowest clear bit below lim in one group; sets it on success
    function automatic bit claim_lowest(input logic kind, input int unsigned grp,
                                        input int unsigned lim, output int unsigned pos);
        logic [ngba_pkg::WORD_W-1:0] word;
        logic [ngba_pkg::WORD_W-1:0] avail;
        int unsigned                 base;
        int unsigned                 idx;
        int                          w;
        int                          b;
        pos = 0;
        for (w = 0; w < WORDS_PER_GROUP; w++)
        begin
            base = 32'(w) * 32;
            if (base >= lim)
                return 1'b0;
            idx   = grp * WORDS_PER_GROUP + 32'(w);
            word  = (kind == ngba_pkg::KIND_INODE) ? inode_bits[idx] : block_bits[idx];
            avail = ~word;
            if (lim - base < 32)
                avail &= (32'h1 << (lim - base)) - 32'h1;
            for (b = 0; b < 32; b++)
            begin
                if (avail[b])
                begin
                    word[b] = 1'b1;
                    if (kind == ngba_pkg::KIND_INODE)
                        inode_bits[idx] = word;
                    else
                        block_bits[idx] = word;
                    pos = base + 32'(b);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic grant_t serve_request(input logic [ngba_pkg::IN_USER_W-1:0] user,
                                             input logic [ngba_pkg::IN_DATA_W-1:0] data);
        logic                        cmd;
        logic                        kind;
        int unsigned                 home;
        int unsigned                 widx;
        logic [ngba_pkg::WORD_W-1:0] wdata;
        int unsigned                 gc;
        int unsigned                 per;
        int unsigned                 lim;
        int unsigned                 span;
        int unsigned                 d;
        int unsigned                 g;
        int unsigned                 pos;
        int                          side;
        grant_t                      r;
        cmd   = user[0];
        kind  = user[1];
        home  = 32'(data[ngba_pkg::GROUP_W-1:0]);
        widx  = 32'(data[ngba_pkg::GROUP_W +: ngba_pkg::WIDX_W]);
        wdata = data[ngba_pkg::GROUP_W+ngba_pkg::WIDX_W +: ngba_pkg::WORD_W];
        r     = '0;
        if (cmd == ngba_pkg::CMD_LOAD)
        begin
            if (home < MAX_GROUPS && widx < WORDS_PER_GROUP)
            begin
                if (kind == ngba_pkg::KIND_INODE)
                    inode_bits[home * WORDS_PER_GROUP + widx] = wdata;
                else
                    block_bits[home * WORDS_PER_GROUP + widx] = wdata;
                r.found = 1'b1;
            end
            return r;
        end
        gc   = (32'(cur_group_count) < MAX_GROUPS) ? 32'(cur_group_count) : MAX_GROUPS;
        per  = (kind == ngba_pkg::KIND_INODE) ? 32'(cur_inodes) : 32'(cur_blocks);
        lim  = (per < BIT_CAP) ? per : BIT_CAP;
        span = ((home > gc) ? home : gc) + 1;
        // home, home-1, home+1, home-2, ... skipping groups not in use
        for (d = 0; d < span; d++)
        begin
            for (side = 0; side < 2; side++)
            begin
                if (side == 0)
                begin
                    if (home < d)
                        continue;
                    g = home - d;
                end
                else
                begin
                    if (d == 0)
                        continue;
                    g = home + d;
                end
                if (g >= gc)
                    continue;
                if (claim_lowest(kind, g, lim, pos))
                begin
                    r.found     = 1'b1;
                    r.object_id = g * per + pos + ((kind == ngba_pkg::KIND_INODE) ? 1 : 0);
                    return r;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_WORDS; i++)
            begin
                inode_bits[i] = '0;
                block_bits[i] = '0;
            end
            cur_group_count = ngba_pkg::GROUP_COUNT_RST;
            cur_inodes      = ngba_pkg::PER_GROUP_RST;
            cur_blocks      = ngba_pkg::PER_GROUP_RST;
            pending_grants.delete();
            unanswered = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    ngba_pkg::REG_GROUP_COUNT:
                        cur_group_count = cfg_data[ngba_pkg::GC_W-1:0];
                    ngba_pkg::REG_INODE_COUNT:
                        cur_inodes      = cfg_data[ngba_pkg::PER_W-1:0];
                    ngba_pkg::REG_BLOCK_COUNT:
                        cur_blocks      = cfg_data[ngba_pkg::PER_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_grants.push_back(serve_request(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (pending_grants.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result found=%0b id=%0d",
                                              m_tuser[0], m_tdata));
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (m_tuser[0] !== want.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  m_tuser[0], want.found));
                    if (m_tdata !== want.object_id)
                        report_mismatch($sformatf("object_id %0d, expected %0d",
                                                  m_tdata, want.object_id));
                end
            end
            unanswered = pending_grants.size();
        end
    end

endmodule

// ===== test/tb_nearest_group_bitmap_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_group_bitmap_allocator
// Drives loads and allocations into the allocator under a series of
// register settings, with random gaps and stalls on both streams; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_nearest_group_bitmap_allocator;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 4200;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_we;
    logic [ngba_pkg::CFG_IDX_W-1:0]      cfg_addr;
    logic [ngba_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [ngba_pkg::IN_USER_W-1:0]      s_tuser;   // cmd, kind
    logic [ngba_pkg::IN_DATA_W-1:0]      s_tdata;   // group, word_index, word_data, pad
    logic                                m_tvalid;
    logic                                m_tready;
    logic [ngba_pkg::OUT_USER_W-1:0]     m_tuser;   // found
    logic [ngba_pkg::OUT_DATA_W-1:0]     m_tdata;   // object_id

    int          fail_count;
    int          sent_cnt   = 0;
    int          got_cnt    = 0;
    int unsigned cycles_run = 0;
    bit          calm       = 1'b0;
    bit          hold_req   = 1'b0;
    int unsigned span_words;

    always #6 clk = ~clk;

    nearest_group_bitmap_allocator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    ngba_result_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .fail_count (fail_count)
    );

    always @(posedge clk)
    begin
        cycles_run <= cycles_run + 1;
        if (m_tvalid && m_tready)
            got_cnt <= got_cnt + 1;
    end

    initial
    begin
        wait (cycles_run >= CYCLE_LIMIT);
        $display("nearest_group_bitmap_allocator test failed");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_req(input logic cmd, input logic kind,
                            input logic [ngba_pkg::GROUP_W-1:0] grp,
                            input logic [ngba_pkg::WIDX_W-1:0] idx,
                            input logic [ngba_pkg::WORD_W-1:0] word);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {kind, cmd};
        s_tdata  <= {4'b0, word, idx, grp};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_cnt++;
    endtask

    // Mostly allocations; loads aim at the words that the scan can reach
    task automatic send_random();
        logic                        cmd;
        logic [ngba_pkg::WIDX_W-1:0] idx;
        logic [ngba_pkg::WORD_W-1:0] word;
        cmd = ($urandom_range(0, 99) < 65) ? ngba_pkg::CMD_ALLOC : ngba_pkg::CMD_LOAD;
        idx = ($urandom_range(0, 9) == 0)
            ? ngba_pkg::WIDX_W'($urandom_range(0, 255))
            : ngba_pkg::WIDX_W'($urandom_range(0, span_words - 1));
        case ($urandom_range(0, 3))
            0:       word = '0;
            1:       word = '1;
            2:       word = $urandom & $urandom & $urandom;
            default: word = $urandom;
        endcase
        send_req(cmd, 1'($urandom_range(0, 1)),
                 ngba_pkg::GROUP_W'($urandom_range(0, 15)), idx, word);
    endtask

    // Waits until every result is back, then writes all three registers
    task automatic set_config(input int unsigned gc, input int unsigned ipg,
                              input int unsigned bpg);
        int unsigned wide;
        s_tvalid <= 1'b0;
        while (got_cnt < sent_cnt) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= ngba_pkg::REG_GROUP_COUNT;
        cfg_data <= ngba_pkg::CFG_DATA_W'(gc);
        @(posedge clk);
        cfg_addr <= ngba_pkg::REG_INODE_COUNT;
        cfg_data <= ngba_pkg::CFG_DATA_W'(ipg);
        @(posedge clk);
        cfg_addr <= ngba_pkg::REG_BLOCK_COUNT;
        cfg_data <= ngba_pkg::CFG_DATA_W'(bpg);
        @(posedge clk);
        cfg_we <= 1'b0;
        wide = (ipg > bpg) ? ipg : bpg;
        span_words = (wide + 31) / 32;
        if (span_words > 256)
            span_words = 256;
        if (span_words == 0)
            span_words = 1;
    endtask

    function automatic int unsigned pick_per();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 32;
            2:       return $urandom_range(1, 40);
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    initial
    begin
        int unsigned gc;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_addr <= ngba_pkg::REG_GROUP_COUNT;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        span_words = 256;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty maps, full-word and edge-index loads
        send_req(ngba_pkg::CMD_ALLOC, ngba_pkg::KIND_BLOCK, 4'd0, 8'd0, 32'h0);
        send_req(ngba_pkg::CMD_ALLOC, ngba_pkg::KIND_INODE, 4'd15, 8'd255, 32'hFFFF_FFFF);
        send_req(ngba_pkg::CMD_LOAD, ngba_pkg::KIND_BLOCK, 4'd0, 8'd0, 32'hFFFF_FFFF);
        send_req(ngba_pkg::CMD_ALLOC, ngba_pkg::KIND_BLOCK, 4'd0, 8'd0, 32'h0);
        send_req(ngba_pkg::CMD_LOAD, ngba_pkg::KIND_INODE, 4'd15, 8'd255, 32'hFFFF_FFFF);
        send_req(ngba_pkg::CMD_LOAD, ngba_pkg::KIND_INODE, 4'd15, 8'd0, 32'h0);
        send_req(ngba_pkg::CMD_ALLOC, ngba_pkg::KIND_INODE, 4'd15, 8'd0, 32'h0);
        send_req(ngba_pkg::CMD_LOAD, ngba_pkg::KIND_BLOCK, 4'd9, 8'd128, 32'hA5A5_A5A5);
        send_req(ngba_pkg::CMD_LOAD, ngba_pkg::KIND_BLOCK, 4'd9, 8'd0, 32'h7FFF_FFFF);
        send_req(ngba_pkg::CMD_ALLOC, ngba_pkg::KIND_BLOCK, 4'd9, 8'd0, 32'h0);
        send_req(ngba_pkg::CMD_ALLOC, ngba_pkg::KIND_BLOCK, 4'd9, 8'd0, 32'h0);
        send_req(ngba_pkg::CMD_LOAD, ngba_pkg::KIND_BLOCK, 4'd15, 8'd255, 32'h0);
        send_req(ngba_pkg::CMD_ALLOC, ngba_pkg::KIND_INODE, 4'd0, 8'd0, 32'h0);
        send_req(ngba_pkg::CMD_LOAD, ngba_pkg::KIND_INODE, 4'd0, 8'd1, 32'h5A5A_5A5A);
        send_req(ngba_pkg::CMD_ALLOC, ngba_pkg::KIND_BLOCK, 4'd7, 8'd0, 32'h0);

        // No group in use
        set_config(0, 40, 40);
        repeat (20) send_random();
        // No object scanned in any group
        set_config(16, 0, 0);
        repeat (20) send_random();
        // Few groups, one or two objects each: home often out of use, maps fill up
        set_config(3, 1, 2);
        repeat (40) send_random();
        // Oversized counts: group count capped, inode scan capped, id uses raw value
        set_config(31, 16383, 8192);
        repeat (30) send_random();

        for (int p = 0; p < 13; p++)
        begin
            case ($urandom_range(0, 5))
                0:       gc = 0;
                1:       gc = $urandom_range(17, 31);
                default: gc = $urandom_range(1, 16);
            endcase
            set_config(gc, pick_per(), pick_per());
            if (p == 3)
                hold_req = 1'b1;
            if (p == 12)
                calm = 1'b1;
            repeat (110) send_random();
        end

        s_tvalid <= 1'b0;
        while (got_cnt < sent_cnt) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("nearest_group_bitmap_allocator test passed");
        else
            $display("nearest_group_bitmap_allocator test failed");
        $finish;
    end

endmodule
